[rtl/core/dss_pkg.sv]
package dss_pkg;

  localparam int FUNC_W = 2;
  localparam int DATA_W = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W = 8;
  localparam int CAP_RESET = 100;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_LOW  = 2'd0,
    FUNC_PUSH_HIGH = 2'd1,
    FUNC_POP_LOW   = 2'd2,
    FUNC_POP_HIGH  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic exec;
  } dss_cmd_t;

endpackage

[rtl/core/dss_req_if.sv]
interface dss_req_if;
  import dss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] push_value;

  modport source(output valid, output func, output push_value, input ready);
  modport sink(input valid, input func, input push_value, output ready);
endinterface

[rtl/core/dss_rsp_if.sv]
interface dss_rsp_if;
  import dss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pop_value;
  logic [STATUS_W-1:0]      status;

  modport source(output valid, output pop_value, output status, input ready);
  modport sink(input valid, input pop_value, input status, output ready);
endinterface

[rtl/core/dss_ctrl.sv]
module dss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output dss_pkg::dss_cmd_t cmd
);
  import dss_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RESULT
  } state_t;

  state_t state;

  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = (state == ST_RESULT);
  assign cmd.exec  = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (rsp_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule

[rtl/core/dss_datapath.sv]
module dss_datapath #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  dss_pkg::dss_cmd_t                cmd,
  input  logic [dss_pkg::FUNC_W-1:0]       func,
  input  logic signed [dss_pkg::DATA_W-1:0] push_value,
  input  logic                             cfg_we,
  input  logic [dss_pkg::CFG_W-1:0]        cfg_wdata,
  output logic signed [dss_pkg::DATA_W-1:0] pop_value,
  output logic [dss_pkg::STATUS_W-1:0]     status
);
  import dss_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int PW = $clog2(MAX_ENTRIES + 1);
  localparam int CW = (PW > CFG_W) ? PW : CFG_W;
  localparam int CAP_RESET_EFF = (CAP_RESET > MAX_ENTRIES) ? MAX_ENTRIES : CAP_RESET;

  logic [DATA_W-1:0] mem [MAX_ENTRIES];

  logic [PW-1:0]     low_cnt;
  logic [PW-1:0]     high_bot;
  logic [PW-1:0]     cap_eff;
  logic [DATA_W-1:0] rd_data;
  logic              from_mem;
  status_t           res_status;

  logic [PW-1:0]     low_cnt_next;
  logic [PW-1:0]     high_bot_next;
  logic [PW-1:0]     cap_sat;
  logic [PW-1:0]     ptr;
  logic              mem_we;
  logic              mem_re;
  status_t           status_next;
  func_t             op;

  always_comb begin
    if (CW'(cfg_wdata) > CW'(MAX_ENTRIES)) begin
      cap_sat = PW'(MAX_ENTRIES);
    end else begin
      cap_sat = PW'(cfg_wdata);
    end
  end

  always_comb begin
    op            = func_t'(func);
    low_cnt_next  = low_cnt;
    high_bot_next = high_bot;
    ptr           = low_cnt;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    status_next   = STATUS_DONE;
    unique case (op)
      FUNC_PUSH_LOW: begin
        ptr = low_cnt;
        if (low_cnt < high_bot) begin
          mem_we       = 1'b1;
          low_cnt_next = low_cnt + PW'(1);
        end else begin
          status_next = STATUS_FULL;
        end
      end
      FUNC_PUSH_HIGH: begin
        ptr = high_bot - PW'(1);
        if (high_bot > low_cnt) begin
          mem_we        = 1'b1;
          high_bot_next = high_bot - PW'(1);
        end else begin
          status_next = STATUS_FULL;
        end
      end
      FUNC_POP_LOW: begin
        ptr = low_cnt - PW'(1);
        if (low_cnt != '0) begin
          mem_re       = 1'b1;
          low_cnt_next = low_cnt - PW'(1);
        end else begin
          status_next = STATUS_EMPTY;
        end
      end
      FUNC_POP_HIGH: begin
        ptr = high_bot;
        if (high_bot < cap_eff) begin
          mem_re        = 1'b1;
          high_bot_next = high_bot + PW'(1);
        end else begin
          status_next = STATUS_EMPTY;
        end
      end
      default: begin
        status_next = STATUS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[ptr[AW-1:0]] <= push_value;
    end
    if (cmd.exec && mem_re) begin
      rd_data <= mem[ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_cnt    <= '0;
      high_bot   <= PW'(CAP_RESET_EFF);
      cap_eff    <= PW'(CAP_RESET_EFF);
      from_mem   <= 1'b0;
      res_status <= STATUS_DONE;
    end else if (cfg_we) begin
      low_cnt  <= '0;
      high_bot <= cap_sat;
      cap_eff  <= cap_sat;
    end else if (cmd.exec) begin
      low_cnt    <= low_cnt_next;
      high_bot   <= high_bot_next;
      from_mem   <= mem_re;
      res_status <= status_next;
    end
  end

  always_comb begin
    if (from_mem) begin
      pop_value = rd_data;
    end else if (res_status == STATUS_EMPTY) begin
      pop_value = EMPTY_VALUE;
    end else begin
      pop_value = '0;
    end
  end

  assign status = res_status;
endmodule

[rtl/core/dual_stack_shared_memory.sv]
// The result of an item is offered in the cycle after the item is accepted.
// A new item is taken only after the previous result has been taken, since the
// block holds one item at a time.
// Reset empties both stacks and sets the capacity to 100, saturated at MAX_ENTRIES.
// Memory contents are not cleared; an entry is only read after it was pushed.
module dual_stack_shared_memory #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic                       clk,
  input  logic                       rst,
  dss_req_if.sink                    req,
  dss_rsp_if.source                  rsp,
  input  logic                       cfg_we,
  input  logic [dss_pkg::CFG_W-1:0]  cfg_wdata
);
  import dss_pkg::*;

  dss_cmd_t cmd;

  dss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  dss_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .func       (req.func),
    .push_value (req.push_value),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .pop_value  (rsp.pop_value),
    .status     (rsp.status)
  );
endmodule

[tb/dss_tb_pkg.sv]
`timescale 1ns / 100ps

package dss_tb_pkg;
  import dss_pkg::*;

  localparam int STORE_DEPTH = 128;

  typedef struct {
    logic [DATA_W-1:0] pop_value;
    status_t           status;
  } stack_reply_t;

  class stack_pair_tracker;
    logic [DATA_W-1:0] words [STORE_DEPTH];
    int unsigned low_count;
    int unsigned high_bottom;
    int unsigned cap_eff;
    stack_reply_t replies [$];
    int unsigned ops_seen;
    int unsigned full_count;
    int unsigned empty_count;
    int unsigned errors;

    function new();
      set_capacity(CFG_W'(CAP_RESET));
    endfunction

    // A capacity write empties both stacks.
    function void set_capacity(logic [CFG_W-1:0] cap);
      cap_eff = (cap > STORE_DEPTH) ? STORE_DEPTH : cap;
      low_count = 0;
      high_bottom = cap_eff;
    endfunction

    function void note_op(func_t op, logic [DATA_W-1:0] value);
      stack_reply_t r;
      r.pop_value = '0;
      r.status = STATUS_DONE;
      case (op)
        FUNC_PUSH_LOW: begin
          if (low_count < high_bottom) begin
            words[low_count] = value;
            low_count++;
          end else begin
            r.status = STATUS_FULL;
          end
        end
        FUNC_PUSH_HIGH: begin
          if (high_bottom > low_count) begin
            high_bottom--;
            words[high_bottom] = value;
          end else begin
            r.status = STATUS_FULL;
          end
        end
        FUNC_POP_LOW: begin
          if (low_count > 0) begin
            low_count--;
            r.pop_value = words[low_count];
          end else begin
            r.pop_value = EMPTY_VALUE;
            r.status = STATUS_EMPTY;
          end
        end
        default: begin
          if (high_bottom < cap_eff) begin
            r.pop_value = words[high_bottom];
            high_bottom++;
          end else begin
            r.pop_value = EMPTY_VALUE;
            r.status = STATUS_EMPTY;
          end
        end
      endcase
      if (r.status == STATUS_FULL) full_count++;
      if (r.status == STATUS_EMPTY) empty_count++;
      ops_seen++;
      replies.push_back(r);
    endfunction

    function void check_reply(logic [DATA_W-1:0] pop_value, logic [STATUS_W-1:0] status);
      stack_reply_t e;
      if (replies.size() == 0) begin
        $error("Reply with no operation outstanding: pop_value %h, status %0d",
               pop_value, status);
        errors++;
        return;
      end
      e = replies.pop_front();
      if (pop_value !== e.pop_value) begin
        $error("pop_value: expected %h, actual %h", e.pop_value, pop_value);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
    endfunction
  endclass

endpackage

[tb/tb_dual_stack_shared_memory.sv]
`timescale 1ns / 100ps

module tb_dual_stack_shared_memory;
  import dss_pkg::*;
  import dss_tb_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_PHASES = 8;
  localparam int RANDOM_CAP = -1;
  localparam int PHASE_CAP [NUM_PHASES] = '{128, 255, 1, 2, 0, RANDOM_CAP, 100, RANDOM_CAP};
  localparam int PHASE_SRC [NUM_PHASES] = '{0, 66, 0, 31, 0, 0, 66, 31};
  localparam int PHASE_SINK [NUM_PHASES] = '{0, 0, 66, 31, 0, 0, 0, 66};
  localparam int PHASE_LEN [NUM_PHASES] = '{260, 220, 150, 150, 100, 250, 220, 350};
  localparam int PRESSURE_PHASE = 5;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  dss_req_if req_bus ();
  dss_rsp_if rsp_bus ();

  stack_pair_tracker tracker;
  int src_idle_pct;
  int sink_stall_pct;
  int hold_left;
  int quiet_cycles;
  int cfg_writes;

  dual_stack_shared_memory u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_bus),
    .rsp       (rsp_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && req_bus.valid && req_bus.ready) begin
      tracker.note_op(func_t'(req_bus.func), req_bus.push_value);
    end
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      tracker.check_reply(rsp_bus.pop_value, rsp_bus.status);
    end
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    quiet_cycles = 0;
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [DATA_W-1:0] random_word();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input func_t op, input logic [DATA_W-1:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.func <= op;
    req_bus.push_value <= value;
    do @(posedge clk); while (!req_bus.ready);
    @(negedge clk);
  endtask

  task automatic drain_replies();
    req_bus.valid <= 1'b0;
    while (tracker.replies.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] cap);
    drain_replies();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_capacity(cap);
    cfg_writes++;
  endtask

  // Runs alternate between filling, draining and balanced traffic, each long
  // enough for a filling or draining run to reach a full or empty store at the current capacity.
  task automatic run_random(input int n_items);
    int bias;
    int run_len;
    int run_idx;
    func_t op;
    run_len = tracker.cap_eff + 24;
    run_idx = 0;
    bias = 95;
    for (int i = 0; i < n_items; i++) begin
      if (i % run_len == 0) begin
        case (run_idx % 3)
          0: bias = 95;
          1: bias = 8;
          default: bias = 50;
        endcase
        run_idx++;
      end
      if ($urandom_range(99) < bias) begin
        op = $urandom_range(1) ? FUNC_PUSH_HIGH : FUNC_PUSH_LOW;
      end else begin
        op = $urandom_range(1) ? FUNC_POP_HIGH : FUNC_POP_LOW;
      end
      send_item(op, random_word());
    end
  endtask

  initial begin
    int cap;
    tracker = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_bus.valid = 1'b0;
    req_bus.func = FUNC_PUSH_LOW;
    req_bus.push_value = '0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_left = 0;
    cfg_writes = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(FUNC_POP_LOW, $urandom);
    send_item(FUNC_POP_HIGH, $urandom);
    send_item(FUNC_PUSH_LOW, 32'h7fff_ffff);
    send_item(FUNC_PUSH_LOW, 32'h8000_0000);
    send_item(FUNC_PUSH_HIGH, 32'h0000_0000);
    send_item(FUNC_PUSH_HIGH, 32'hffff_ffff);
    send_item(FUNC_POP_HIGH, $urandom);
    send_item(FUNC_POP_LOW, $urandom);
    send_item(FUNC_POP_HIGH, $urandom);
    send_item(FUNC_POP_LOW, $urandom);
    send_item(FUNC_POP_HIGH, $urandom);

    // With no entries in use, every push is full and every pop is empty.
    write_capacity(8'd0);
    send_item(FUNC_PUSH_LOW, $urandom);
    send_item(FUNC_PUSH_HIGH, $urandom);
    send_item(FUNC_POP_LOW, $urandom);
    send_item(FUNC_POP_HIGH, $urandom);

    write_capacity(8'd1);
    send_item(FUNC_PUSH_HIGH, 32'ha5a5_a5a5);
    send_item(FUNC_PUSH_LOW, $urandom);
    send_item(FUNC_POP_LOW, $urandom);
    send_item(FUNC_POP_HIGH, $urandom);
    send_item(FUNC_PUSH_LOW, 32'h5a5a_5a5a);
    send_item(FUNC_PUSH_HIGH, $urandom);

    // The capacity write must discard the item left on stack one, and the
    // oversized capacity saturates at the store depth.
    write_capacity(8'd255);
    send_item(FUNC_POP_LOW, $urandom);
    send_item(FUNC_POP_HIGH, $urandom);
    send_item(FUNC_PUSH_HIGH, $urandom);
    send_item(FUNC_POP_HIGH, $urandom);

    for (int p = 0; p < NUM_PHASES; p++) begin
      cap = (PHASE_CAP[p] == RANDOM_CAP) ? $urandom_range(127, 3) : PHASE_CAP[p];
      write_capacity(CFG_W'(cap));
      src_idle_pct = PHASE_SRC[p];
      sink_stall_pct = PHASE_SINK[p];
      if (p == PRESSURE_PHASE) hold_left = HOLD_CYCLES;
      run_random(PHASE_LEN[p]);
    end
    drain_replies();

    $display("Checked %0d stack operations over %0d capacity settings, from zero to saturated.",
             tracker.ops_seen, cfg_writes);
    $display("Pushes refused as full: %0d; pops that found an empty stack: %0d.",
             tracker.full_count, tracker.empty_count);
    if (tracker.errors == 0 && tracker.replies.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (tracker.replies.size() != 0) begin
        $error("%0d replies never arrived", tracker.replies.size());
      end
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
